@@ hdl/signed_int_to_decimal_ascii_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the decimal text converter
// Clocked property checks used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH

// check outside reset
`define SIDA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check that also holds while reset is asserted
`define SIDA_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/sida_pkg.sv @@
// ----------------------------------------------------------------------------
// sida_pkg
// Types and constants for the signed integer to decimal text converter.
// ----------------------------------------------------------------------------
`default_nettype none

package sida_pkg;

	localparam int BIN_W      = 32;             // input magnitude width
	localparam int BCD_DIGITS = 10;             // decimal digits of a 32-bit magnitude
	localparam int BCD_W      = 4 * BCD_DIGITS; // packed BCD width
	localparam int CNT_W      = 4;              // holds 0..BCD_DIGITS
	localparam int STEP_W     = 5;              // indexes BIN_W shift steps
	localparam int CHAR_W     = 6;              // ASCII code field width
	localparam int TDATA_OUT_W = 8;             // char_code padded to a byte

	localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
	localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;

	typedef enum logic [2:0] {
		ST_IDLE,  // waiting for a value
		ST_CONV,  // double-dabble shift steps
		ST_SKIP,  // drop leading zero digits
		ST_SIGN,  // emit minus sign
		ST_EMIT   // emit digits, most significant first
	} state_t;

endpackage

`default_nettype wire

@@ hdl/signed_int_to_decimal_ascii.sv @@
// Sequence: 32 shift/add-3 steps, then leading zero digits are dropped, then the minus sign
// (for negatives) and the digits go out one beat per character, most significant first.
// Flow: one value at a time; a new value is accepted only once its last character is loaded;
// the single shift/add-3 unit is reused over 32 steps, and output is one beat per cycle while m_axis_tready allows.
// Reset: arst_n clears the sequencer and the output valid; datapath registers are not reset.
`default_nettype none
`include "signed_int_to_decimal_ascii_defines.svh"

// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a signed 32-bit value to ASCII decimal text, one character per beat.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// input stream
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  wire logic [sida_pkg::BIN_W-1:0]       s_axis_tdata,  // [31:0] value
	// output stream
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	output logic [sida_pkg::TDATA_OUT_W-1:0]      m_axis_tdata,  // [5:0] char_code, [7:6] zero
	output logic                                  m_axis_tlast   // last_char
);
	import sida_pkg::*;

	// sequencer
	state_t state_q, state_d;

	// datapath registers
	logic [BIN_W-1:0]  bin_q;    // magnitude, shifted out MSB first
	logic [BCD_W-1:0]  bcd_q;    // BCD accumulator; top digit is the next to emit
	logic [STEP_W-1:0] step_q;   // shift step index
	logic [CNT_W-1:0]  cnt_q;    // digits still to emit
	logic              neg_q;

	// output register
	logic              out_valid_q;
	logic [CHAR_W-1:0] out_char_q;
	logic              out_last_q;

	// control from the output decode
	logic              accept;
	logic              conv_step;
	logic              skip_shift;
	logic              dig_shift;
	logic              out_load;
	logic [CHAR_W-1:0] out_char;
	logic              out_last;

	logic              out_free;
	logic [3:0]        top_digit;
	logic              last_step;
	logic [BCD_W-1:0]  bcd_adj;
	logic [BIN_W-1:0]  magnitude;

	assign out_free  = !out_valid_q || m_axis_tready;
	assign top_digit = bcd_q[BCD_W-1 -: 4];
	assign last_step = (step_q == STEP_W'(BIN_W - 1));

	// two's complement negate; the most negative value maps onto itself as unsigned
	assign magnitude = s_axis_tdata[BIN_W-1] ? (BIN_W'(0) - s_axis_tdata) : s_axis_tdata;

	// shared add-3 unit: every BCD digit of 5 or more gets 3 added before the shift
	always_comb begin
		for (int d = 0; d < BCD_DIGITS; d++) begin
			bcd_adj[4*d +: 4] = (bcd_q[4*d +: 4] >= 4'd5) ? (bcd_q[4*d +: 4] + 4'd3)
			                                               : bcd_q[4*d +: 4];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) state_d = ST_CONV;
			end
			ST_CONV: begin
				if (last_step) state_d = ST_SKIP;
			end
			ST_SKIP: begin
				if (!((top_digit == 4'd0) && (cnt_q > CNT_W'(1)))) begin
					state_d = neg_q ? ST_SIGN : ST_EMIT;
				end
			end
			ST_SIGN: begin
				if (out_free) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free && (cnt_q == CNT_W'(1))) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_axis_tready = 1'b0;
		accept        = 1'b0;
		conv_step     = 1'b0;
		skip_shift    = 1'b0;
		dig_shift     = 1'b0;
		out_load      = 1'b0;
		out_char      = ASCII_ZERO;
		out_last      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				accept        = s_axis_tvalid;
			end
			ST_CONV: begin
				conv_step = 1'b1;
			end
			ST_SKIP: begin
				skip_shift = (top_digit == 4'd0) && (cnt_q > CNT_W'(1));
			end
			ST_SIGN: begin
				out_load = out_free;
				out_char = ASCII_MINUS;
			end
			ST_EMIT: begin
				out_load  = out_free;
				dig_shift = out_free;
				out_char  = ASCII_ZERO + {2'b00, top_digit};
				out_last  = (cnt_q == CNT_W'(1));
			end
			default: begin
				s_axis_tready = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			bin_q  <= magnitude;
			bcd_q  <= '0;
			step_q <= '0;
			cnt_q  <= CNT_W'(BCD_DIGITS);
			neg_q  <= s_axis_tdata[BIN_W-1];
		end else if (conv_step) begin
			bcd_q  <= {bcd_adj[BCD_W-2:0], bin_q[BIN_W-1]};
			bin_q  <= {bin_q[BIN_W-2:0], 1'b0};
			step_q <= step_q + STEP_W'(1);
		end else if (skip_shift || dig_shift) begin
			bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
			cnt_q <= cnt_q - CNT_W'(1);
		end
		if (out_load) begin
			out_char_q <= out_char;
			out_last_q <= out_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_char_q};
	assign m_axis_tlast  = out_last_q;

	// checks
	`SIDA_ASSERT(a_one_at_a_time, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready,
		"second value accepted while converting")
	`SIDA_ASSERT(a_char_range, m_axis_tvalid |-> ((m_axis_tdata == 8'd45) ||
		((m_axis_tdata >= 8'd48) && (m_axis_tdata <= 8'd57))), "bad character code")
	`SIDA_ASSERT(a_emit_count, (state_q == ST_EMIT) |-> (cnt_q != '0),
		"digit count ran out while emitting")
	// valid is only known to be clear once a reset edge has been seen
	`SIDA_ASSERT_RST(a_reset_quiet, !arst_n |=> !m_axis_tvalid, "output valid during reset")

endmodule

`default_nettype wire
